// ----- hdl/assert_macros.svh -----
// Assertion helpers used by slstk_dp.sv; sampled on the rising clock edge,
// off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every edge.
`define SLSTK_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that a condition at one edge is followed by another at the next edge.
`define SLSTK_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- hdl/slstk_pkg.sv -----
package slstk_pkg;

   localparam int STACK_DEPTH = 128;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int WORD_W      = 32;
   localparam int KIND_W      = 2;
   localparam int ECNT_W      = 8;
   localparam int RSP_DATA_W  = 80;

   localparam logic [WORD_W-1:0] WORD_NONE = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH = 2'd0,
      KIND_POP  = 2'd1,
      KIND_SORT = 2'd2,
      KIND_NOP  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_KEY,
      S_CMP,
      S_PUT,
      S_TOP_RD,
      S_TOP_WAIT,
      S_RESP
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_PUSH,
      OP_POP,
      OP_HOLD,
      OP_SORT_START,
      OP_KEY_LOAD,
      OP_SHIFT,
      OP_PUT,
      OP_TOP_RD,
      OP_TOP_LOAD,
      OP_LOAD_RSP
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic empty;      // no entries
      logic full;       // entry count at depth
      logic few;        // at most one entry
      logic greater;    // read word above the key, signed
      logic j_one;      // insert position at 1
      logic key_last;   // current key is the top entry
      logic slot_free;  // output register can take a word
   } status_type;

endpackage

// ----- hdl/slstk_ram.sv -----
module slstk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/slstk_ctrl.sv -----
module slstk_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [slstk_pkg::KIND_W-1:0] req_kind,
   input  slstk_pkg::status_type        status,
   output slstk_pkg::cmd_type           cmd
);

   import slstk_pkg::*;

   state_type state_ff;
   state_type state_in;
   kind_type  kind;

   assign kind = kind_type'(req_kind);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (kind)
                  KIND_POP: begin
                     state_in = (!status.empty && !status.few) ? S_TOP_WAIT : S_RESP;
                  end
                  KIND_SORT: begin
                     state_in = status.few ? S_RESP : S_KEY;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_KEY: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (status.greater) begin
               state_in = status.j_one ? S_PUT : S_CMP;
            end else begin
               state_in = status.key_last ? S_TOP_RD : S_KEY;
            end
         end
         S_PUT: begin
            state_in = status.key_last ? S_TOP_RD : S_KEY;
         end
         S_TOP_RD: begin
            state_in = S_TOP_WAIT;
         end
         S_TOP_WAIT: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (status.slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd.op     = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (kind)
                  KIND_PUSH: cmd.op = OP_PUSH;
                  KIND_POP:  cmd.op = OP_POP;
                  KIND_SORT: cmd.op = status.few ? OP_HOLD : OP_SORT_START;
                  default:   cmd.op = OP_HOLD;
               endcase
            end
         end
         S_KEY: begin
            cmd.op = OP_KEY_LOAD;
         end
         S_CMP: begin
            cmd.op = status.greater ? OP_SHIFT : OP_PUT;
         end
         S_PUT: begin
            cmd.op = OP_PUT;
         end
         S_TOP_RD: begin
            cmd.op = OP_TOP_RD;
         end
         S_TOP_WAIT: begin
            cmd.op = OP_TOP_LOAD;
         end
         S_RESP: begin
            if (status.slot_free) begin
               cmd.op = OP_LOAD_RSP;
            end
         end
         default: begin
            cmd.op = OP_NONE;
         end
      endcase
   end

endmodule

// ----- hdl/slstk_dp.sv -----
`include "assert_macros.svh"

module slstk_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  slstk_pkg::cmd_type                cmd,
   input  logic [slstk_pkg::WORD_W-1:0]      push_value,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [slstk_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output slstk_pkg::status_type             status
);

   import slstk_pkg::*;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [WORD_W-1:0]     top_ff, top_in;
   logic [WORD_W-1:0]     key_ff, key_in;
   logic [WORD_W-1:0]     popped_ff, popped_in;
   logic                  dropped_ff, dropped_in;
   logic [ADDR_W-1:0]     i_ff, i_in;
   logic [ADDR_W-1:0]     j_ff, j_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [WORD_W-1:0]     wr_data;
   logic [ADDR_W-1:0]     rd_addr;
   logic [WORD_W-1:0]     rd_data;
   logic [WORD_W-1:0]     top_out;

   slstk_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign status.empty     = (count_ff == '0);
   assign status.full      = (count_ff == CNT_W'(STACK_DEPTH));
   assign status.few       = (count_ff < CNT_W'(2));
   assign status.greater   = ($signed(rd_data) > $signed(key_ff));
   assign status.j_one     = (j_ff == ADDR_W'(1));
   assign status.key_last  = ((CNT_W'(i_ff) + CNT_W'(1)) == count_ff);
   assign status.slot_free = !rsp_valid_ff || rsp_tready;

   assign top_out = status.empty ? WORD_NONE : top_ff;

   always_comb begin
      count_in   = count_ff;
      top_in     = top_ff;
      key_in     = key_ff;
      popped_in  = popped_ff;
      dropped_in = dropped_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      wr_en      = 1'b0;
      wr_addr    = j_ff;
      wr_data    = rd_data;
      rd_addr    = j_ff - ADDR_W'(2);
      case (cmd.op)
         OP_PUSH: begin
            popped_in = '0;
            if (status.full) begin
               dropped_in = 1'b1;
            end else begin
               dropped_in = 1'b0;
               wr_en      = 1'b1;
               wr_addr    = ADDR_W'(count_ff);
               wr_data    = push_value;
               top_in     = push_value;
               count_in   = count_ff + CNT_W'(1);
            end
         end
         OP_POP: begin
            if (status.empty) begin
               popped_in  = WORD_NONE;
               dropped_in = 1'b1;
            end else begin
               popped_in  = top_ff;
               dropped_in = 1'b0;
               count_in   = count_ff - CNT_W'(1);
               // fetch the word below the one leaving
               rd_addr    = ADDR_W'(count_ff - CNT_W'(2));
            end
         end
         OP_HOLD: begin
            popped_in  = '0;
            dropped_in = 1'b0;
         end
         OP_SORT_START: begin
            popped_in  = '0;
            dropped_in = 1'b0;
            i_in       = ADDR_W'(1);
            rd_addr    = ADDR_W'(1);
         end
         OP_KEY_LOAD: begin
            key_in  = rd_data;
            j_in    = i_ff;
            rd_addr = i_ff - ADDR_W'(1);
         end
         OP_SHIFT: begin
            // move the larger word up one place and look one further down
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = rd_data;
            j_in    = j_ff - ADDR_W'(1);
            rd_addr = j_ff - ADDR_W'(2);
         end
         OP_PUT: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = key_ff;
            i_in    = i_ff + ADDR_W'(1);
            rd_addr = i_ff + ADDR_W'(1);
         end
         OP_TOP_RD: begin
            rd_addr = ADDR_W'(count_ff - CNT_W'(1));
         end
         OP_TOP_LOAD: begin
            top_in = rd_data;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.op == OP_LOAD_RSP) begin
         rsp_data_in = {5'b0, dropped_ff, status.full, status.empty,
                        ECNT_W'(count_ff), top_out, popped_ff};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == OP_LOAD_RSP) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      key_ff      <= key_in;
      popped_ff   <= popped_in;
      dropped_ff  <= dropped_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SLSTK_ASSERT(a_count_bound, count_ff <= CNT_W'(STACK_DEPTH), "entry count above depth")
   `SLSTK_ASSERT(a_shift_above_bottom, (cmd.op != OP_SHIFT) || (j_ff != '0), "shift at bottom entry")
   `SLSTK_ASSERT(a_load_slot_free, (cmd.op != OP_LOAD_RSP) || status.slot_free, "result overwrites waiting word")
   `SLSTK_ASSERT_NEXT(a_push_grows, (cmd.op == OP_PUSH) && !status.full, count_ff == $past(count_ff) + CNT_W'(1), "push did not grow stack")

endmodule

// ----- hdl/sortable_lifo_stack_top.sv -----
// Channel   Direction  Handshake                Payload
// req       in         req_tvalid / req_tready  tuser kind, tdata push_value
// rsp       out        rsp_tvalid / rsp_tready  tdata result word
//
// Push, kind 3, a dropped pop, a pop of the last entry and a sort of fewer than two
// entries go straight to the result; any other pop first waits on a registered RAM
// read for the new top. A sort is an insertion sort that moves one word at a time
// through the single read port of the stack RAM with its registered read.
// Reset clears the entry count and control; the RAM is not cleared.
// A result waits while rsp_tready is low; the next request is taken, its result holds.
module sortable_lifo_stack_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [slstk_pkg::KIND_W-1:0]      req_tuser,  // [1:0] kind
   input  logic [slstk_pkg::WORD_W-1:0]      req_tdata,  // [31:0] push_value
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] popped_value, [63:32] top_value, [71:64] entry_count,
   // [72] is_empty, [73] is_full, [74] dropped, [79:75] zero
   output logic [slstk_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   import slstk_pkg::*;

   cmd_type    cmd;
   status_type status;

   slstk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   slstk_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .push_value (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .status     (status)
   );

endmodule
